// ===== sv/srpt_pkg.sv =====
// Shared types and constants for the sorted ring peer table.
// No dependencies; used by srpt_mem, srpt_cmp and sorted_ring_peer_table.
package srpt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int CMD_W       = 3;
  localparam int PORT_W      = 16;
  localparam int ADDR_W      = 32;
  localparam int POS_W       = 5;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 6;
  localparam int ENTRY_W     = PORT_W + ADDR_W;

  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_NEIGH  = 3'd2,
    OP_READ   = 3'd3,
    OP_MEMBER = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PUT,
    S_RDWAIT,
    S_DONE
  } state_t;

  // write request into the entry store
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] data;
  } wr_req_t;

  // result of the shared key compare
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== sv/srpt_mem.sv =====
// Entry store: port and address per slot, one write and one registered read.
// Depends on srpt_pkg.
module srpt_mem (
  input  logic                         clk,
  input  srpt_pkg::wr_req_t            wr,
  input  logic [srpt_pkg::IDX_W-1:0]   rd_addr,
  output logic [srpt_pkg::ENTRY_W-1:0] rd_data
);

  logic [srpt_pkg::ENTRY_W-1:0] mem [srpt_pkg::TABLE_DEPTH];
  logic [srpt_pkg::ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/srpt_cmp.sv =====
// Shared key comparator used by the scan: equality and less-than on ports.
// Depends on srpt_pkg.
module srpt_cmp (
  input  logic [srpt_pkg::PORT_W-1:0] key,
  input  logic [srpt_pkg::PORT_W-1:0] entry,
  output srpt_pkg::cmp_res_t          res
);

  always_comb begin
    res.eq = (entry == key);
    res.lt = (entry < key);
  end

endmodule

// ===== sv/sorted_ring_peer_table.sv =====
// Sorted ring peer table: sequencer around one entry store and one comparator.
// Each command scans the entries held, then decides and gives its result; a read adds a wait
// on the store, an insert adds a shift of the entries above its slot and a put, a remove adds a shift.
// Busy for the whole command, so a new command is taken only after the last result; results
// cannot be stalled. Reset clears the state, the count and the scan flags, not the entry store.
// Depends on srpt_pkg, srpt_mem, srpt_cmp.
module sorted_ring_peer_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [srpt_pkg::CMD_W-1:0]       in_command,
  input  logic [srpt_pkg::PORT_W-1:0]      in_peer_port,
  input  logic [srpt_pkg::ADDR_W-1:0]      in_peer_address,
  input  logic [srpt_pkg::POS_W-1:0]       in_position,
  output logic                             out_valid,
  output logic [srpt_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_is_member,
  output logic                             out_first_valid,
  output logic [srpt_pkg::PORT_W-1:0]      out_first_neighbour,
  output logic                             out_second_valid,
  output logic [srpt_pkg::PORT_W-1:0]      out_second_neighbour,
  output logic [srpt_pkg::PORT_W-1:0]      out_port_out,
  output logic [srpt_pkg::ADDR_W-1:0]      out_address_out,
  output logic [srpt_pkg::COUNT_OUT_W-1:0] out_count_out
);

  localparam int IDX_W  = srpt_pkg::IDX_W;
  localparam int CNT_W  = srpt_pkg::CNT_W;
  localparam int PORT_W = srpt_pkg::PORT_W;
  localparam int ADDR_W = srpt_pkg::ADDR_W;

  srpt_pkg::state_t state_r, state_nxt;

  logic [srpt_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [PORT_W-1:0]             key_r, key_nxt;
  logic [ADDR_W-1:0]             addr_r, addr_nxt;
  logic [srpt_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              ptr_r, ptr_nxt;
  logic                          dv_r, dv_nxt;
  logic [CNT_W-1:0]              di_r, di_nxt;
  logic                          found_r, found_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [CNT_W-1:0]              slot_r, slot_nxt;
  logic [PORT_W-1:0]             first_r, first_nxt;
  logic [PORT_W-1:0]             last_r, last_nxt;
  logic [PORT_W-1:0]             prev_r, prev_nxt;
  logic [PORT_W-1:0]             pred_r, pred_nxt;
  logic [PORT_W-1:0]             next_r, next_nxt;
  logic                          want_next_r, want_next_nxt;
  srpt_pkg::status_t             status_r, status_nxt;
  logic                          fv_r, fv_nxt;
  logic [PORT_W-1:0]             fn_r, fn_nxt;
  logic                          sv_r, sv_nxt;
  logic [PORT_W-1:0]             sn_r, sn_nxt;
  logic [PORT_W-1:0]             pout_r, pout_nxt;
  logic [ADDR_W-1:0]             aout_r, aout_nxt;

  srpt_pkg::wr_req_t             wr;
  logic [IDX_W-1:0]              rd_addr;
  logic [srpt_pkg::ENTRY_W-1:0]  rd_data;
  logic [PORT_W-1:0]             rd_port;
  srpt_pkg::cmp_res_t            cmp;
  logic                          scan_issue;
  logic                          shift_issue;
  logic                          is_insert;
  logic                          accept;

  assign accept      = start && (state_r == srpt_pkg::S_IDLE);
  assign is_insert   = (cmd_r == srpt_pkg::OP_INSERT);
  assign rd_port     = rd_data[srpt_pkg::ENTRY_W-1:ADDR_W];
  assign scan_issue  = (ptr_r < count_r);
  assign shift_issue = is_insert ? (ptr_r > slot_r) : (ptr_r < count_r);

  srpt_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srpt_cmp u_cmp (
    .key   (key_r),
    .entry (rd_port),
    .res   (cmp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srpt_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = srpt_pkg::S_SCAN;
        end
      end
      srpt_pkg::S_SCAN: begin
        if (!scan_issue && !dv_r) begin
          state_nxt = srpt_pkg::S_DECIDE;
        end
      end
      srpt_pkg::S_DECIDE: begin
        case (cmd_r)
          srpt_pkg::OP_INSERT: begin
            if (!found_r && count_r < CNT_W'(srpt_pkg::TABLE_DEPTH)) begin
              state_nxt = srpt_pkg::S_SHIFT;
            end else begin
              state_nxt = srpt_pkg::S_DONE;
            end
          end
          srpt_pkg::OP_REMOVE: begin
            state_nxt = found_r ? srpt_pkg::S_SHIFT : srpt_pkg::S_DONE;
          end
          srpt_pkg::OP_READ: begin
            state_nxt = (CNT_W'(pos_r) < count_r) ? srpt_pkg::S_RDWAIT : srpt_pkg::S_DONE;
          end
          default: state_nxt = srpt_pkg::S_DONE;
        endcase
      end
      srpt_pkg::S_SHIFT: begin
        if (!shift_issue && !dv_r) begin
          state_nxt = is_insert ? srpt_pkg::S_PUT : srpt_pkg::S_DONE;
        end
      end
      srpt_pkg::S_PUT:    state_nxt = srpt_pkg::S_DONE;
      srpt_pkg::S_RDWAIT: state_nxt = srpt_pkg::S_DONE;
      srpt_pkg::S_DONE:   state_nxt = srpt_pkg::S_IDLE;
      default:            state_nxt = srpt_pkg::S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    dv_nxt        = 1'b0;
    di_nxt        = di_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    prev_nxt      = prev_r;
    pred_nxt      = pred_r;
    next_nxt      = next_r;
    want_next_nxt = want_next_r;
    status_nxt    = status_r;
    fv_nxt        = fv_r;
    fn_nxt        = fn_r;
    sv_nxt        = sv_r;
    sn_nxt        = sn_r;
    pout_nxt      = pout_r;
    aout_nxt      = aout_r;
    rd_addr       = ptr_r[IDX_W-1:0];
    wr.en         = 1'b0;
    wr.addr       = slot_r[IDX_W-1:0];
    wr.data       = {key_r, addr_r};

    case (state_r)
      srpt_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_command;
          key_nxt       = in_peer_port;
          addr_nxt      = in_peer_address;
          pos_nxt       = in_position;
          ptr_nxt       = '0;
          found_nxt     = 1'b0;
          slot_nxt      = '0;
          want_next_nxt = 1'b0;
          status_nxt    = srpt_pkg::ST_OK;
          fv_nxt        = 1'b0;
          fn_nxt        = '0;
          sv_nxt        = 1'b0;
          sn_nxt        = '0;
          pout_nxt      = '0;
          aout_nxt      = '0;
        end
      end
      srpt_pkg::S_SCAN: begin
        if (scan_issue) begin
          ptr_nxt = ptr_r + 1'b1;
          dv_nxt  = 1'b1;
          di_nxt  = ptr_r;
        end
        if (dv_r) begin
          prev_nxt = rd_port;
          if (cmp.lt) begin
            slot_nxt = slot_r + 1'b1;
          end
          if (di_r == '0) begin
            first_nxt = rd_port;
          end
          if (di_r == count_r - 1'b1) begin
            last_nxt = rd_port;
          end
          if (want_next_r) begin
            next_nxt      = rd_port;
            want_next_nxt = 1'b0;
          end
          // ports are unique, so at most one hit
          if (cmp.eq) begin
            found_nxt     = 1'b1;
            idx_nxt       = di_r[IDX_W-1:0];
            pred_nxt      = prev_r;
            want_next_nxt = 1'b1;
          end
        end
      end
      srpt_pkg::S_DECIDE: begin
        rd_addr = pos_r;
        case (cmd_r)
          srpt_pkg::OP_INSERT: begin
            ptr_nxt = count_r;
            if (found_r) begin
              status_nxt = srpt_pkg::ST_DUP;
            end else if (count_r >= CNT_W'(srpt_pkg::TABLE_DEPTH)) begin
              status_nxt = srpt_pkg::ST_FULL;
            end
          end
          srpt_pkg::OP_REMOVE: begin
            ptr_nxt = CNT_W'(idx_r) + 1'b1;
            if (!found_r) begin
              status_nxt = srpt_pkg::ST_ABSENT;
            end
          end
          srpt_pkg::OP_NEIGH: begin
            if (!found_r) begin
              status_nxt = srpt_pkg::ST_ABSENT;
            end else if (count_r == CNT_W'(2)) begin
              fv_nxt = 1'b1;
              fn_nxt = (idx_r == '0) ? last_r : first_r;
            end else if (count_r > CNT_W'(2)) begin
              fv_nxt = 1'b1;
              fn_nxt = (idx_r == '0) ? last_r : pred_r;
              sv_nxt = 1'b1;
              sn_nxt = (CNT_W'(idx_r) == count_r - 1'b1) ? first_r : next_r;
            end
          end
          srpt_pkg::OP_READ: begin
            if (CNT_W'(pos_r) >= count_r) begin
              status_nxt = srpt_pkg::ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      srpt_pkg::S_SHIFT: begin
        // read one slot per cycle, write it one place over on the next
        if (shift_issue) begin
          dv_nxt = 1'b1;
          if (is_insert) begin
            rd_addr = IDX_W'(ptr_r - 1'b1);
            ptr_nxt = ptr_r - 1'b1;
            di_nxt  = ptr_r - 1'b1;
          end else begin
            rd_addr = ptr_r[IDX_W-1:0];
            ptr_nxt = ptr_r + 1'b1;
            di_nxt  = ptr_r;
          end
        end
        if (dv_r) begin
          wr.en   = 1'b1;
          wr.addr = is_insert ? IDX_W'(di_r + 1'b1) : IDX_W'(di_r - 1'b1);
          wr.data = rd_data;
        end
        if (!shift_issue && !dv_r && !is_insert) begin
          count_nxt = count_r - 1'b1;
        end
      end
      srpt_pkg::S_PUT: begin
        wr.en     = 1'b1;
        count_nxt = count_r + 1'b1;
      end
      srpt_pkg::S_RDWAIT: begin
        pout_nxt = rd_port;
        aout_nxt = rd_data[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srpt_pkg::S_IDLE;
      count_r     <= '0;
      dv_r        <= 1'b0;
      want_next_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
      want_next_r <= want_next_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    addr_r   <= addr_nxt;
    pos_r    <= pos_nxt;
    ptr_r    <= ptr_nxt;
    di_r     <= di_nxt;
    found_r  <= found_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    prev_r   <= prev_nxt;
    pred_r   <= pred_nxt;
    next_r   <= next_nxt;
    status_r <= status_nxt;
    fv_r     <= fv_nxt;
    fn_r     <= fn_nxt;
    sv_r     <= sv_nxt;
    sn_r     <= sn_nxt;
    pout_r   <= pout_nxt;
    aout_r   <= aout_nxt;
  end

  assign busy                 = (state_r != srpt_pkg::S_IDLE);
  assign out_valid            = (state_r == srpt_pkg::S_DONE);
  assign out_status           = status_r;
  assign out_is_member        = found_r;
  assign out_first_valid      = fv_r;
  assign out_first_neighbour  = fn_r;
  assign out_second_valid     = sv_r;
  assign out_second_neighbour = sn_r;
  assign out_port_out         = pout_r;
  assign out_address_out      = aout_r;
  assign out_count_out        = srpt_pkg::COUNT_OUT_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(srpt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == srpt_pkg::ST_FULL) |->
      (count_r == CNT_W'(srpt_pkg::TABLE_DEPTH)))
    else $error("full status with room left");

  a_neigh_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_second_valid) |-> out_first_valid)
    else $error("second neighbour without first");

endmodule

// ===== dv/sorted_ring_peer_table_tb.sv =====
// Self-checking testbench for sorted_ring_peer_table: directed command script, then
// fill/drain/mixed random episodes, checked against an in-bench table predictor or typed rows.
// Depends on srpt_pkg and the sorted_ring_peer_table RTL.
module sorted_ring_peer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [srpt_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [srpt_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [srpt_pkg::CMD_W-1:0] CMD_SPARE_C = 3'd7;
  localparam int RANDOM_ITEMS  = 825;
  localparam int EPISODE_LEN   = 55;
  localparam int POOL_SIZE     = 48;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 80;
  localparam int N_SCRIPT      = 24;

  typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED} episode_t;

  typedef struct packed {
    srpt_pkg::status_t                  status;
    logic                               is_member;
    logic                               first_valid;
    logic [srpt_pkg::PORT_W-1:0]        first_port;
    logic                               second_valid;
    logic [srpt_pkg::PORT_W-1:0]        second_port;
    logic [srpt_pkg::PORT_W-1:0]        port;
    logic [srpt_pkg::ADDR_W-1:0]        addr;
    logic [srpt_pkg::COUNT_OUT_W-1:0]   count;
  } peer_reply_t;

  // typed expectations cover status, membership, first neighbour (valid and port) and count;
  // every other field of a typed row is zero
  typedef struct packed {
    logic [srpt_pkg::CMD_W-1:0]       cmd;
    logic [srpt_pkg::PORT_W-1:0]      port;
    logic [srpt_pkg::ADDR_W-1:0]      addr;
    logic [srpt_pkg::POS_W-1:0]       pos;
    logic                             typed;
    srpt_pkg::status_t                st;
    logic                             mem;
    logic                             fv;
    logic [srpt_pkg::PORT_W-1:0]      fn;
    logic [srpt_pkg::COUNT_OUT_W-1:0] cnt;
  } script_row_t;

  script_row_t script [N_SCRIPT] = '{
    '{srpt_pkg::OP_READ, 16'h0000, 32'h0000_0000, 5'd0,
      1'b1, srpt_pkg::ST_RANGE, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_NEIGH, 16'h1234, 32'h0000_0000, 5'd0,
      1'b1, srpt_pkg::ST_ABSENT, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_REMOVE, 16'hFFFF, 32'h0000_0000, 5'd0,
      1'b1, srpt_pkg::ST_ABSENT, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_MEMBER, 16'h0000, 32'h0000_0000, 5'd0,
      1'b1, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 5'd0,
      1'b1, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd1},
    '{srpt_pkg::OP_NEIGH, 16'hFFFF, 32'h0000_0000, 5'd0,
      1'b1, srpt_pkg::ST_OK, 1'b1, 1'b0, 16'h0000, 6'd1},
    '{srpt_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, 5'd31,
      1'b1, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd2},
    '{srpt_pkg::OP_NEIGH, 16'h0000, 32'h0000_0000, 5'd0,
      1'b1, srpt_pkg::ST_OK, 1'b1, 1'b1, 16'hFFFF, 6'd2},
    '{srpt_pkg::OP_INSERT, 16'h0000, 32'h0000_0005, 5'd0,
      1'b1, srpt_pkg::ST_DUP, 1'b1, 1'b0, 16'h0000, 6'd2},
    '{srpt_pkg::OP_INSERT, 16'h8000, 32'hA5A5_A5A5, 5'd0,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_NEIGH, 16'h8000, 32'h0000_0000, 5'd0,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_NEIGH, 16'h0000, 32'h0000_0000, 5'd0,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_NEIGH, 16'hFFFF, 32'h0000_0000, 5'd0,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_READ, 16'h4321, 32'h0000_0000, 5'd2,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_READ, 16'h4321, 32'h0000_0000, 5'd31,
      1'b1, srpt_pkg::ST_RANGE, 1'b0, 1'b0, 16'h0000, 6'd3},
    '{srpt_pkg::OP_READ, 16'h4321, 32'h0000_0000, 5'd3,
      1'b1, srpt_pkg::ST_RANGE, 1'b0, 1'b0, 16'h0000, 6'd3},
    '{srpt_pkg::OP_READ, 16'h4321, 32'h0000_0000, 5'd0,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_MEMBER, 16'h8000, 32'h0000_0000, 5'd0,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{CMD_SPARE_A, 16'h8000, 32'h1234_5678, 5'd1,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{CMD_SPARE_B, 16'h1111, 32'h0000_0000, 5'd0,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{CMD_SPARE_C, 16'hFFFF, 32'hFFFF_FFFF, 5'd31,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_REMOVE, 16'h8000, 32'h0000_0000, 5'd0,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0},
    '{srpt_pkg::OP_REMOVE, 16'h8000, 32'h0000_0000, 5'd0,
      1'b1, srpt_pkg::ST_ABSENT, 1'b0, 1'b0, 16'h0000, 6'd2},
    '{srpt_pkg::OP_READ, 16'h4321, 32'h0000_0000, 5'd1,
      1'b0, srpt_pkg::ST_OK, 1'b0, 1'b0, 16'h0000, 6'd0}
  };

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic [srpt_pkg::CMD_W-1:0]       in_command = '0;
  logic [srpt_pkg::PORT_W-1:0]      in_peer_port = '0;
  logic [srpt_pkg::ADDR_W-1:0]      in_peer_address = '0;
  logic [srpt_pkg::POS_W-1:0]       in_position = '0;
  logic                             out_valid;
  logic [srpt_pkg::STATUS_W-1:0]    out_status;
  logic                             out_is_member;
  logic                             out_first_valid;
  logic [srpt_pkg::PORT_W-1:0]      out_first_neighbour;
  logic                             out_second_valid;
  logic [srpt_pkg::PORT_W-1:0]      out_second_neighbour;
  logic [srpt_pkg::PORT_W-1:0]      out_port_out;
  logic [srpt_pkg::ADDR_W-1:0]      out_address_out;
  logic [srpt_pkg::COUNT_OUT_W-1:0] out_count_out;

  // typed expectation travels with the command it belongs to
  logic        row_typed = 1'b0;
  peer_reply_t row_want = '0;

  // predictor copy of the table
  logic [srpt_pkg::PORT_W-1:0] ring_port [srpt_pkg::TABLE_DEPTH];
  logic [srpt_pkg::ADDR_W-1:0] ring_addr [srpt_pkg::TABLE_DEPTH];
  int                          ring_count = 0;

  peer_reply_t                 pending_replies[$];
  logic [srpt_pkg::PORT_W-1:0] port_pool [POOL_SIZE];
  int mismatches   = 0;
  int sent_count   = 0;
  int results_seen = 0;
  int full_rejects = 0;
  int ring_queries = 0;

  sorted_ring_peer_table u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_peer_port         (in_peer_port),
    .in_peer_address      (in_peer_address),
    .in_position          (in_position),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_is_member        (out_is_member),
    .out_first_valid      (out_first_valid),
    .out_first_neighbour  (out_first_neighbour),
    .out_second_valid     (out_second_valid),
    .out_second_neighbour (out_second_neighbour),
    .out_port_out         (out_port_out),
    .out_address_out      (out_address_out),
    .out_count_out        (out_count_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic peer_reply_t apply_peer_command(
      input logic [srpt_pkg::CMD_W-1:0]  cmd,
      input logic [srpt_pkg::PORT_W-1:0] port,
      input logic [srpt_pkg::ADDR_W-1:0] addr,
      input logic [srpt_pkg::POS_W-1:0]  pos);
    peer_reply_t r;
    int hit;
    int slot;
    int i;
    r = '0;
    hit = ring_count;
    for (i = 0; i < ring_count; i++)
      if (ring_port[i] == port && hit == ring_count) hit = i;
    r.is_member = (hit < ring_count);
    case (cmd)
      srpt_pkg::OP_INSERT: begin
        if (r.is_member) begin
          r.status = srpt_pkg::ST_DUP;
        end else if (ring_count >= srpt_pkg::TABLE_DEPTH) begin
          r.status = srpt_pkg::ST_FULL;
          full_rejects++;
        end else begin
          slot = 0;
          while (slot < ring_count && ring_port[slot] < port) slot++;
          for (i = ring_count; i > slot; i--) begin
            ring_port[i] = ring_port[i-1];
            ring_addr[i] = ring_addr[i-1];
          end
          ring_port[slot] = port;
          ring_addr[slot] = addr;
          ring_count++;
        end
      end
      srpt_pkg::OP_REMOVE: begin
        if (!r.is_member) begin
          r.status = srpt_pkg::ST_ABSENT;
        end else begin
          for (i = hit; i + 1 < ring_count; i++) begin
            ring_port[i] = ring_port[i+1];
            ring_addr[i] = ring_addr[i+1];
          end
          ring_count--;
        end
      end
      srpt_pkg::OP_NEIGH: begin
        if (!r.is_member) begin
          r.status = srpt_pkg::ST_ABSENT;
        end else if (ring_count == 2) begin
          r.first_valid = 1'b1;
          r.first_port  = ring_port[(hit == 0) ? 1 : 0];
        end else if (ring_count >= 3) begin
          // ring wraps at both ends
          r.first_valid  = 1'b1;
          r.first_port   = ring_port[(hit == 0) ? ring_count - 1 : hit - 1];
          r.second_valid = 1'b1;
          r.second_port  = ring_port[(hit + 1 == ring_count) ? 0 : hit + 1];
          ring_queries++;
        end
      end
      srpt_pkg::OP_READ: begin
        if (pos >= ring_count) begin
          r.status = srpt_pkg::ST_RANGE;
        end else begin
          r.port = ring_port[pos];
          r.addr = ring_addr[pos];
        end
      end
      default: ;
    endcase
    r.count = srpt_pkg::COUNT_OUT_W'(ring_count);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [srpt_pkg::ADDR_W-1:0] got,
                                 input logic [srpt_pkg::ADDR_W-1:0] want);
    $display("ERROR at %0t: %s got 0x%0h, want 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // compare result transfers first, then log the command transfer at this edge
  always @(posedge clk) begin : reply_monitor
    peer_reply_t head;
    peer_reply_t pred;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, '0);
        end else begin
          head = pending_replies.pop_front();
          if (out_status !== head.status)
            report_mismatch("status", out_status, head.status);
          if (out_is_member !== head.is_member)
            report_mismatch("is_member", out_is_member, head.is_member);
          if (out_first_valid !== head.first_valid)
            report_mismatch("first_valid", out_first_valid, head.first_valid);
          if (out_first_neighbour !== head.first_port)
            report_mismatch("first_neighbour", out_first_neighbour, head.first_port);
          if (out_second_valid !== head.second_valid)
            report_mismatch("second_valid", out_second_valid, head.second_valid);
          if (out_second_neighbour !== head.second_port)
            report_mismatch("second_neighbour", out_second_neighbour, head.second_port);
          if (out_port_out !== head.port)
            report_mismatch("port_out", out_port_out, head.port);
          if (out_address_out !== head.addr)
            report_mismatch("address_out", out_address_out, head.addr);
          if (out_count_out !== head.count)
            report_mismatch("count_out", out_count_out, head.count);
        end
      end
      if (start && !busy) begin
        pred = apply_peer_command(in_command, in_peer_port, in_peer_address, in_position);
        pending_replies.push_back(row_typed ? row_want : pred);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic issue_cmd(input logic [srpt_pkg::CMD_W-1:0] cmd,
                           input logic [srpt_pkg::PORT_W-1:0] port,
                           input logic [srpt_pkg::ADDR_W-1:0] addr,
                           input logic [srpt_pkg::POS_W-1:0] pos,
                           input logic typed, input peer_reply_t want);
    start           <= 1'b1;
    in_command      <= cmd;
    in_peer_port    <= port;
    in_peer_address <= addr;
    in_position     <= pos;
    row_typed       <= typed;
    row_want        <= want;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  task automatic idle_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic random_item(input episode_t mode, input int idle_pct);
    logic [srpt_pkg::CMD_W-1:0]  cmd;
    logic [srpt_pkg::PORT_W-1:0] port;
    int r;
    r = $urandom_range(99);
    if (mode == EP_FILL && r < 85) begin
      cmd = srpt_pkg::OP_INSERT;
    end else if (mode == EP_DRAIN && r < 85) begin
      cmd = srpt_pkg::OP_REMOVE;
    end else begin
      r = $urandom_range(99);
      if (r < 20)      cmd = srpt_pkg::OP_INSERT;
      else if (r < 40) cmd = srpt_pkg::OP_REMOVE;
      else if (r < 65) cmd = srpt_pkg::OP_NEIGH;
      else if (r < 80) cmd = srpt_pkg::OP_READ;
      else if (r < 92) cmd = srpt_pkg::OP_MEMBER;
      else             cmd = srpt_pkg::CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
    end
    // mostly reuse known ports so removes and queries hit present peers
    if ($urandom_range(99) < 80) port = port_pool[$urandom_range(POOL_SIZE - 1)];
    else                         port = srpt_pkg::PORT_W'($urandom);
    issue_cmd(cmd, port, srpt_pkg::ADDR_W'($urandom), srpt_pkg::POS_W'($urandom_range(31)),
              1'b0, '0);
    idle_gap(idle_pct);
  endtask

  initial begin : stimulus
    peer_reply_t want;
    int n;
    int phase;
    int idle_pct;
    int phase_sent;
    int k;
    episode_t mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < N_SCRIPT; n++) begin
      want             = '0;
      want.status      = script[n].st;
      want.is_member   = script[n].mem;
      want.first_valid = script[n].fv;
      want.first_port  = script[n].fn;
      want.count       = script[n].cnt;
      issue_cmd(script[n].cmd, script[n].port, script[n].addr, script[n].pos,
                script[n].typed, want);
      idle_gap(31);
    end

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
      for (k = 0; k < POOL_SIZE; k++) port_pool[k] = srpt_pkg::PORT_W'($urandom);
      port_pool[0] = '0;
      port_pool[1] = '1;
      phase_sent = 0;
      while (phase_sent < RANDOM_ITEMS / 3) begin
        mode = episode_t'($urandom_range(EP_MIXED));
        for (k = 0; k < EPISODE_LEN; k++) random_item(mode, idle_pct);
        phase_sent += EPISODE_LEN;
      end
      // hold off until the block has answered every transfer so far
      start <= 1'b0;
      while (results_seen < sent_count) @(posedge clk);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_replies.size() != 0) begin
      report_mismatch("missing result, status", '0, pending_replies[0].status);
      void'(pending_replies.pop_front());
    end

    $display("Summary: %0d commands (%0d scripted), %0d results compared", sent_count,
             N_SCRIPT, results_seen);
    $display("Summary: %0d inserts refused on a full table, %0d ring queries with 3+ peers",
             full_rejects, ring_queries);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
sv/srpt_pkg.sv
sv/srpt_mem.sv
sv/srpt_cmp.sv
sv/sorted_ring_peer_table.sv
dv/sorted_ring_peer_table_tb.sv
